@@ rtl/ljf_pkg.sv @@
// ----------------------------------------------------------------------------
// ljf_pkg
// Shared widths, request and status codes, micro-op set and the control
// store of the longest-job-first dispatcher.
// ----------------------------------------------------------------------------
package ljf_pkg;

  localparam int unsigned MaxJobsDef = 64;

  localparam int unsigned ReqW  = 2;
  localparam int unsigned StatW = 2;
  localparam int unsigned ArrW  = 32;
  localparam int unsigned DurW  = 16;
  localparam int unsigned TimeW = 32;

  localparam logic [ReqW-1:0] ReqLoad     = 2'd0;
  localparam logic [ReqW-1:0] ReqDispatch = 2'd1;
  localparam logic [ReqW-1:0] ReqRestart  = 2'd2;

  localparam logic [StatW-1:0] StLoaded     = 2'd0;
  localparam logic [StatW-1:0] StDispatched = 2'd1;
  localparam logic [StatW-1:0] StFull       = 2'd2;
  localparam logic [StatW-1:0] StNone       = 2'd3;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_FREE,
    OP_EARLY,
    OP_DECIDE,
    OP_BEST,
    OP_COMMIT
  } uop_e;

  localparam int unsigned UpcW = 3;

  localparam logic [UpcW-1:0] UpcIdle   = 3'd0;
  localparam logic [UpcW-1:0] UpcLoad   = 3'd1;
  localparam logic [UpcW-1:0] UpcEarly  = 3'd2;
  localparam logic [UpcW-1:0] UpcDecide = 3'd3;
  localparam logic [UpcW-1:0] UpcBest   = 3'd4;
  localparam logic [UpcW-1:0] UpcCommit = 3'd5;

  typedef struct packed {
    uop_e            op;
    logic [UpcW-1:0] next_ok;
    logic [UpcW-1:0] next_alt;
  } uword_t;

  typedef struct packed {
    logic done;
    logic alt;
  } ljf_stat_t;

  function automatic uword_t ljf_rom(input logic [UpcW-1:0] upc);
    uword_t w;
    unique case (upc)
      UpcIdle:   w = '{op: OP_WAIT,   next_ok: UpcLoad,   next_alt: UpcEarly};
      UpcLoad:   w = '{op: OP_FREE,   next_ok: UpcIdle,   next_alt: UpcIdle};
      UpcEarly:  w = '{op: OP_EARLY,  next_ok: UpcDecide, next_alt: UpcDecide};
      UpcDecide: w = '{op: OP_DECIDE, next_ok: UpcBest,   next_alt: UpcIdle};
      UpcBest:   w = '{op: OP_BEST,   next_ok: UpcCommit, next_alt: UpcCommit};
      UpcCommit: w = '{op: OP_COMMIT, next_ok: UpcIdle,   next_alt: UpcIdle};
      default:   w = '{op: OP_WAIT,   next_ok: UpcIdle,   next_alt: UpcIdle};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/ljf_job_mem.sv @@
// ----------------------------------------------------------------------------
// ljf_job_mem
// Job table memory: one write port, one registered read port, each entry
// holding a job's duration and arrival time.
// ----------------------------------------------------------------------------
module ljf_job_mem import ljf_pkg::*; #(
  parameter int unsigned MaxJobs = MaxJobsDef,
  localparam int unsigned IdxW   = $clog2(MaxJobs)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [ArrW-1:0] warr_i,
  input  logic [DurW-1:0] wdur_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [ArrW-1:0] rarr_o,
  output logic [DurW-1:0] rdur_o
);

  logic [DurW+ArrW-1:0] mem [MaxJobs];
  logic [DurW+ArrW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wdur_i, warr_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr_i];
  end

  assign rarr_o = rd_q[ArrW-1:0];
  assign rdur_o = rd_q[DurW+ArrW-1:ArrW];

endmodule

@@ rtl/ljf_sequencer.sv @@
// ----------------------------------------------------------------------------
// ljf_sequencer
// Micro-program counter over the control store; steps on the datapath's
// done flag and takes the alternate jump when the datapath asks for it.
// ----------------------------------------------------------------------------
module ljf_sequencer import ljf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ljf_stat_t stat_i,
  output uop_e      op_o
);

  logic [UpcW-1:0] upc_q, upc_d;
  uword_t          word;

  assign word = ljf_rom(upc_q);
  assign op_o = word.op;

  always_comb begin
    upc_d = upc_q;
    if (stat_i.done) begin
      upc_d = stat_i.alt ? word.next_alt : word.next_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ rtl/ljf_datapath.sv @@
// ----------------------------------------------------------------------------
// ljf_datapath
// Slot valid bits, scan counter, earliest and best trackers, job clock and
// result register, driven one micro-op at a time by the sequencer.
// ----------------------------------------------------------------------------
module ljf_datapath import ljf_pkg::*; #(
  parameter int unsigned MaxJobs = MaxJobsDef,
  localparam int unsigned IdxW   = $clog2(MaxJobs),
  localparam int unsigned CntW   = $clog2(MaxJobs + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  uop_e             op_i,
  output ljf_stat_t        stat_o,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ReqW-1:0]  in_req_i,
  input  logic [ArrW-1:0]  in_arr_i,
  input  logic [DurW-1:0]  in_dur_i,
  output logic             mem_we_o,
  output logic [IdxW-1:0]  mem_waddr_o,
  output logic [ArrW-1:0]  mem_warr_o,
  output logic [DurW-1:0]  mem_wdur_o,
  output logic [IdxW-1:0]  mem_raddr_o,
  input  logic [ArrW-1:0]  mem_rarr_i,
  input  logic [DurW-1:0]  mem_rdur_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [StatW-1:0] out_status_o,
  output logic [DurW-1:0]  out_dur_o,
  output logic [ArrW-1:0]  out_arr_o,
  output logic [TimeW-1:0] out_start_o
);

  logic [MaxJobs-1:0] valid_q, valid_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ptake_q, ptake_d;
  logic               pv_q, pv_d;
  logic [IdxW-1:0]    pidx_q, pidx_d;
  logic               any_q, any_d;
  logic               ready_q, ready_d;
  logic [ArrW-1:0]    earl_q, earl_d;
  logic               have_q, have_d;
  logic [IdxW-1:0]    bidx_q, bidx_d;
  logic [DurW-1:0]    bdur_q, bdur_d;
  logic [ArrW-1:0]    barr_q, barr_d;
  logic [TimeW-1:0]   time_q, time_d;
  logic [ArrW-1:0]    ld_arr_q, ld_arr_d;
  logic [DurW-1:0]    ld_dur_q, ld_dur_d;
  logic               ov_q, ov_d;
  logic [StatW-1:0]   os_q, os_d;
  logic [DurW-1:0]    od_q, od_d;
  logic [ArrW-1:0]    oa_q, oa_d;
  logic [TimeW-1:0]   ot_q, ot_d;

  logic               out_free;
  logic               accept;
  logic               scan_end;
  logic               hit;
  logic [IdxW-1:0]    cidx;
  logic [TimeW:0]     sum;

  assign cidx        = cnt_q[IdxW-1:0];
  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (op_i == OP_WAIT);
  assign accept      = in_valid_i && in_ready_o;
  assign scan_end    = (cnt_q == CntW'(MaxJobs));
  assign hit         = ptake_q && pv_q && (mem_rarr_i <= time_q);
  assign sum         = {1'b0, time_q} + {{(TimeW + 1 - DurW){1'b0}}, bdur_q};
  assign mem_raddr_o = cidx;
  assign mem_waddr_o = cidx;
  assign mem_warr_o  = ld_arr_q;
  assign mem_wdur_o  = ld_dur_q;

  always_comb begin
    valid_d  = valid_q;
    cnt_d    = cnt_q;
    ptake_d  = 1'b0;
    pv_d     = pv_q;
    pidx_d   = pidx_q;
    any_d    = any_q;
    ready_d  = ready_q;
    earl_d   = earl_q;
    have_d   = have_q;
    bidx_d   = bidx_q;
    bdur_d   = bdur_q;
    barr_d   = barr_q;
    time_d   = time_q;
    ld_arr_d = ld_arr_q;
    ld_dur_d = ld_dur_q;
    ov_d     = ov_q && !out_ready_i;
    os_d     = os_q;
    od_d     = od_q;
    oa_d     = oa_q;
    ot_d     = ot_q;
    stat_o   = '{done: 1'b0, alt: 1'b0};
    mem_we_o = 1'b0;

    unique case (op_i)
      OP_WAIT: begin
        cnt_d   = '0;
        any_d   = 1'b0;
        ready_d = 1'b0;
        if (accept) begin
          case (in_req_i)
            ReqLoad: begin
              ld_arr_d = in_arr_i;
              ld_dur_d = in_dur_i;
              stat_o   = '{done: 1'b1, alt: 1'b0};
            end
            ReqDispatch: begin
              stat_o = '{done: 1'b1, alt: 1'b1};
            end
            ReqRestart: begin
              valid_d = '0;
              time_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      OP_FREE: begin
        if (out_free) begin
          if (!valid_q[cidx]) begin
            mem_we_o      = 1'b1;
            valid_d[cidx] = 1'b1;
            ov_d          = 1'b1;
            os_d          = StLoaded;
            od_d          = '0;
            oa_d          = '0;
            ot_d          = '0;
            cnt_d         = '0;
            stat_o        = '{done: 1'b1, alt: 1'b0};
          end else if (cnt_q == CntW'(MaxJobs - 1)) begin
            ov_d   = 1'b1;
            os_d   = StFull;
            od_d   = '0;
            oa_d   = '0;
            ot_d   = '0;
            cnt_d  = '0;
            stat_o = '{done: 1'b1, alt: 1'b0};
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end

      OP_EARLY, OP_BEST: begin
        if (!scan_end) begin
          ptake_d = 1'b1;
          pv_d    = valid_q[cidx];
          pidx_d  = cidx;
          cnt_d   = cnt_q + CntW'(1);
        end else begin
          cnt_d  = '0;
          stat_o = '{done: 1'b1, alt: 1'b0};
        end
        if (op_i == OP_EARLY) begin
          if (ptake_q && pv_q) begin
            if (!any_q || (mem_rarr_i < earl_q)) begin
              earl_d = mem_rarr_i;
            end
            any_d = 1'b1;
            if (mem_rarr_i <= time_q) begin
              ready_d = 1'b1;
            end
          end
        end else if (hit) begin
          if (!have_q || (mem_rdur_i > bdur_q) ||
              ((mem_rdur_i == bdur_q) && (mem_rarr_i < barr_q))) begin
            have_d = 1'b1;
            bidx_d = pidx_q;
            bdur_d = mem_rdur_i;
            barr_d = mem_rarr_i;
          end
        end
      end

      OP_DECIDE: begin
        have_d = 1'b0;
        if (!any_q) begin
          if (out_free) begin
            ov_d   = 1'b1;
            os_d   = StNone;
            od_d   = '0;
            oa_d   = '0;
            ot_d   = '0;
            stat_o = '{done: 1'b1, alt: 1'b1};
          end
        end else begin
          if (!ready_q) begin
            time_d = earl_q;
          end
          stat_o = '{done: 1'b1, alt: 1'b0};
        end
      end

      OP_COMMIT: begin
        if (out_free) begin
          ov_d            = 1'b1;
          os_d            = StDispatched;
          od_d            = bdur_q;
          oa_d            = barr_q;
          ot_d            = time_q;
          time_d          = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
          valid_d[bidx_q] = 1'b0;
          stat_o          = '{done: 1'b1, alt: 1'b0};
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      ptake_q <= 1'b0;
      any_q   <= 1'b0;
      ready_q <= 1'b0;
      have_q  <= 1'b0;
      time_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      ptake_q <= ptake_d;
      any_q   <= any_d;
      ready_q <= ready_d;
      have_q  <= have_d;
      time_q  <= time_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q     <= pv_d;
    pidx_q   <= pidx_d;
    earl_q   <= earl_d;
    bidx_q   <= bidx_d;
    bdur_q   <= bdur_d;
    barr_q   <= barr_d;
    ld_arr_q <= ld_arr_d;
    ld_dur_q <= ld_dur_d;
    os_q     <= os_d;
    od_q     <= od_d;
    oa_q     <= oa_d;
    ot_q     <= ot_d;
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = os_q;
  assign out_dur_o    = od_q;
  assign out_arr_o    = oa_q;
  assign out_start_o  = ot_q;

endmodule

@@ rtl/longest_job_first_dispatcher.sv @@
// ----------------------------------------------------------------------------
// longest_job_first_dispatcher
// Load walks the valid bits to the lowest free slot.
// Dispatch makes two passes over the job memory read port;
// it makes one pass only when the table is empty.
// Restart and unused codes are handled in the wait state; one word in flight at a time.
// A finished result waits in the output register while the next word enters.
// Reset (async, active low) clears valid bits, job clock, micro-pc, output valid and scan state.
// ----------------------------------------------------------------------------
module longest_job_first_dispatcher import ljf_pkg::*; #(
  parameter int unsigned MaxJobs = MaxJobsDef,
  localparam int unsigned IdxW   = $clog2(MaxJobs)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // job_arrival, job_duration
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // picked_duration, picked_arrival, start_time
  output logic [1:0]  m_axis_tuser   // status
);

  uop_e             op;
  ljf_stat_t        stat;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [ArrW-1:0]  mem_warr;
  logic [DurW-1:0]  mem_wdur;
  logic [IdxW-1:0]  mem_raddr;
  logic [ArrW-1:0]  mem_rarr;
  logic [DurW-1:0]  mem_rdur;
  logic [DurW-1:0]  out_dur;
  logic [ArrW-1:0]  out_arr;
  logic [TimeW-1:0] out_start;

  ljf_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  ljf_job_mem #(
    .MaxJobs (MaxJobs)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .warr_i  (mem_warr),
    .wdur_i  (mem_wdur),
    .raddr_i (mem_raddr),
    .rarr_o  (mem_rarr),
    .rdur_o  (mem_rdur)
  );

  ljf_datapath #(
    .MaxJobs (MaxJobs)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .stat_o       (stat),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_req_i     (s_axis_tuser),
    .in_arr_i     (s_axis_tdata[31:0]),
    .in_dur_i     (s_axis_tdata[47:32]),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_warr_o   (mem_warr),
    .mem_wdur_o   (mem_wdur),
    .mem_raddr_o  (mem_raddr),
    .mem_rarr_i   (mem_rarr),
    .mem_rdur_i   (mem_rdur),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_dur_o    (out_dur),
    .out_arr_o    (out_arr),
    .out_start_o  (out_start)
  );

  assign m_axis_tdata = {out_start, out_arr, out_dur};

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the longest-job-first dispatcher. A queued driver
// sends load, dispatch, restart and spare words; a job table and clock kept
// in the bench predict every result, and a monitor checks each result word
// in order. Idling moves between sender and receiver, one long receiver
// hold-off fills the block, and the sender drains at phase boundaries.
// ----------------------------------------------------------------------------
module tb;
  import ljf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned JobSlots = MaxJobsDef;
  localparam logic [ReqW-1:0] ReqSpare = 2'd3;
  localparam int unsigned WordTotal = 1800;
  localparam int unsigned PhaseLen = 600;

  typedef struct {
    logic [ReqW-1:0] kind;
    logic [ArrW-1:0] arrival;
    logic [DurW-1:0] duration;
    bit              drain;
  } job_word_t;

  typedef struct {
    logic [StatW-1:0] status;
    logic [DurW-1:0]  duration;
    logic [ArrW-1:0]  arrival;
    logic [TimeW-1:0] start;
  } pick_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  job_word_t pending_q[$];
  pick_t     pick_q[$];
  job_word_t cur_word;

  logic             slot_used [JobSlots];
  logic [ArrW-1:0]  slot_arrival [JobSlots];
  logic [DurW-1:0]  slot_duration [JobSlots];
  logic [TimeW-1:0] job_clock;

  int unsigned words_in = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned mismatches = 0;

  longest_job_first_dispatcher #(.MaxJobs(JobSlots)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),   // job_arrival, job_duration
    .s_axis_tuser  (s_user),   // req_type
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata), // picked_duration, picked_arrival, start_time
    .m_axis_tuser  (m_axis_tuser)  // status
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #18_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic push_pick(input logic [StatW-1:0] st, input logic [DurW-1:0] dur,
                           input logic [ArrW-1:0] arr, input logic [TimeW-1:0] start);
    pick_t p;
    p.status   = st;
    p.duration = dur;
    p.arrival  = arr;
    p.start    = start;
    pick_q.push_back(p);
  endtask

  task automatic predict_word(input job_word_t w);
    int          free_slot;
    int          best;
    bit          any;
    bit          ready;
    logic [ArrW-1:0] earliest;
    logic [TimeW:0]  sum;
    free_slot = -1;
    best      = -1;
    any       = 1'b0;
    ready     = 1'b0;
    earliest  = '0;
    case (w.kind)
      ReqLoad: begin
        for (int i = 0; i < JobSlots; i++) begin
          if (free_slot < 0 && !slot_used[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          push_pick(StFull, '0, '0, '0);
        end else begin
          slot_used[free_slot]     = 1'b1;
          slot_arrival[free_slot]  = w.arrival;
          slot_duration[free_slot] = w.duration;
          push_pick(StLoaded, '0, '0, '0);
        end
      end
      ReqDispatch: begin
        for (int i = 0; i < JobSlots; i++) begin
          if (slot_used[i]) begin
            if (!any || slot_arrival[i] < earliest) earliest = slot_arrival[i];
            any = 1'b1;
            if (slot_arrival[i] <= job_clock) ready = 1'b1;
          end
        end
        if (!any) begin
          push_pick(StNone, '0, '0, '0);
        end else begin
          if (!ready) job_clock = earliest;
          for (int i = 0; i < JobSlots; i++) begin
            if (slot_used[i] && slot_arrival[i] <= job_clock) begin
              if (best < 0 || slot_duration[i] > slot_duration[best] ||
                  (slot_duration[i] == slot_duration[best] &&
                   slot_arrival[i] < slot_arrival[best])) best = i;
            end
          end
          push_pick(StDispatched, slot_duration[best], slot_arrival[best], job_clock);
          sum = {1'b0, job_clock} + {{(TimeW + 1 - DurW){1'b0}}, slot_duration[best]};
          job_clock = sum[TimeW] ? '1 : sum[TimeW-1:0];
          slot_used[best] = 1'b0;
        end
      end
      ReqRestart: begin
        for (int i = 0; i < JobSlots; i++) slot_used[i] = 1'b0;
        job_clock = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_word(input logic [ReqW-1:0] kind, input logic [ArrW-1:0] arr,
                          input logic [DurW-1:0] dur);
    job_word_t w;
    w.kind     = kind;
    w.arrival  = arr;
    w.duration = dur;
    w.drain    = (pending_q.size() == PhaseLen) || (pending_q.size() == 2 * PhaseLen);
    pending_q.push_back(w);
  endtask

  function automatic int unsigned send_idle_pct(input int unsigned n);
    return (n < PhaseLen) ? 23 : (n < 2 * PhaseLen) ? 67 : 0;
  endfunction

  function automatic int unsigned recv_idle_pct(input int unsigned n);
    return (n < PhaseLen) ? 67 : (n < 2 * PhaseLen) ? 23 : 0;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_user  <= '0;
    end else begin
      if (s_valid && s_axis_tready) begin
        predict_word(cur_word);
        words_in <= words_in + 1;
      end
      if (!s_valid || s_axis_tready) begin
        if (pending_q.size() != 0 && !(pending_q[0].drain && pick_q.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct(words_in)) begin
          cur_word = pending_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= {cur_word.duration, cur_word.arrival};
          s_user  <= cur_word.kind;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, fills the block so its input stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= 300) begin
      hold_left <= 2000;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    pick_t exp_pick;
    pick_t got;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        got.status   = m_axis_tuser;
        got.duration = m_axis_tdata[15:0];
        got.arrival  = m_axis_tdata[47:16];
        got.start    = m_axis_tdata[79:48];
        if (pick_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: st=%0d dur=%h arr=%h start=%h",
                     got.status, got.duration, got.arrival, got.start);
        end else begin
          exp_pick = pick_q.pop_front();
          if (got.status !== exp_pick.status || got.duration !== exp_pick.duration ||
              got.arrival !== exp_pick.arrival || got.start !== exp_pick.start) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %h %h %h got %0d %h %h %h",
                       exp_pick.status, exp_pick.duration, exp_pick.arrival, exp_pick.start,
                       got.status, got.duration, got.arrival, got.start);
          end
        end
      end
      m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct(words_in));
    end
  end

  initial begin
    int unsigned style;
    int unsigned mode;
    int unsigned pick;
    logic [ArrW-1:0] arr;
    logic [DurW-1:0] dur;

    for (int i = 0; i < JobSlots; i++) begin
      slot_used[i]     = 1'b0;
      slot_arrival[i]  = '0;
      slot_duration[i] = '0;
    end
    job_clock = '0;

    // directed: empty table, extremes, ties, idle jump, saturation, restart
    add_word(ReqDispatch, $urandom(), DurW'($urandom()));
    add_word(ReqSpare, $urandom(), DurW'($urandom()));
    add_word(ReqLoad, 32'h0000_0000, 16'h0000);
    add_word(ReqLoad, 32'hFFFF_FFFF, 16'hFFFF);
    add_word(ReqLoad, 32'd5, 16'hFFFF);
    add_word(ReqLoad, 32'd3, 16'hFFFF);
    add_word(ReqLoad, 32'd3, 16'hFFFF);
    add_word(ReqDispatch, '0, '0);
    add_word(ReqDispatch, '0, '0);
    add_word(ReqDispatch, '0, '0);
    add_word(ReqDispatch, '0, '0);
    add_word(ReqDispatch, '0, '0);
    add_word(ReqDispatch, '0, '0);
    add_word(ReqLoad, 32'd10, 16'd1);
    add_word(ReqRestart, $urandom(), DurW'($urandom()));
    add_word(ReqDispatch, '1, '1);
    add_word(ReqLoad, 32'hFFFF_FF00, 16'h8000);
    add_word(ReqLoad, 32'h0000_0000, 16'h7FFF);
    add_word(ReqDispatch, '0, '0);
    add_word(ReqDispatch, '0, '0);
    add_word(ReqSpare, '1, '1);
    add_word(ReqRestart, '1, '1);
    pending_q[$].drain = 1'b1;

    while (pending_q.size() < WordTotal) begin
      style = $urandom_range(0, 99);
      mode  = $urandom_range(0, 2);
      if ($urandom_range(0, 99) < 12) add_word(ReqRestart, $urandom(), DurW'($urandom()));
      repeat ((style < 15) ? 64 + $urandom_range(1, 4) : $urandom_range(10, 40)) begin
        case (mode)
          0: begin
            arr = $urandom_range(0, 300);
            dur = DurW'($urandom_range(0, 12));
          end
          1: begin
            arr = $urandom();
            dur = DurW'($urandom());
          end
          default: begin
            arr = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
            dur = DurW'($urandom_range(0, 16'hFFFF));
          end
        endcase
        pick = (style < 15) ? 0 : $urandom_range(0, 99);
        if (pick < 52) add_word(ReqLoad, arr, dur);
        else if (pick < 95) add_word(ReqDispatch, $urandom(), DurW'($urandom()));
        else if (pick < 98) add_word(ReqSpare, $urandom(), DurW'($urandom()));
        else add_word(ReqRestart, $urandom(), DurW'($urandom()));
      end
      if (style < 15) begin
        repeat ($urandom_range(2, 10)) add_word(ReqDispatch, $urandom(), DurW'($urandom()));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || s_valid) @(posedge clk_i);
    while (pick_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    if (mismatches == 0 && pick_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ljf_pkg.sv
rtl/ljf_job_mem.sv
rtl/ljf_sequencer.sv
rtl/ljf_datapath.sv
rtl/longest_job_first_dispatcher.sv
sim/tb.sv
